// ===== rtl/tte_pkg.sv =====
`default_nettype none
package tte_pkg;

    localparam int PERIOD_W  = 17;
    localparam int TIMEOUT_W = 16;
    localparam int TEMPO_W   = 24;
    localparam int TICK_W    = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam int HISTORY_DEPTH_DEF = 10;

    localparam logic [PERIOD_W-1:0]  TICK_PERIOD_RESET = PERIOD_W'(25000);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = TIMEOUT_W'(120);

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = CFG_IDX_W'(1);

    // Shared divider: 60e6 us per minute times 256 needs 34 bits.
    localparam int DIV_W      = 34;
    localparam int DIV_STEP_W = $clog2(DIV_W);
    localparam logic [DIV_W-1:0] MINUTE_US_Q8 = DIV_W'(64'd15360000000);

    localparam logic [TEMPO_W-1:0] Q8_MAX = {TEMPO_W{1'b1}};

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                 cleared;
        logic [TIMEOUT_W-1:0] ticks;
    } t_job;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_TSTART,
        B_TWAIT,
        B_WRITE,
        B_SUM,
        B_ASTART,
        B_AWAIT
    } t_back_state;

endpackage
`default_nettype wire

// ===== rtl/tte_div.sv =====
`default_nettype none
module tte_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [tte_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [tte_pkg::DIV_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [tte_pkg::DIV_W-1:0]      o_quotient
);
    import tte_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_step;
    logic [DIV_W-1:0]      r_rem;
    logic [DIV_W-1:0]      r_quot;
    logic [DIV_W-1:0]      r_div;
    logic [DIV_W:0]        w_rem_sh;
    logic [DIV_W:0]        w_diff;
    logic                  w_ge;

    // One restoring step per cycle; the dividend shifts out of the quotient register.
    assign w_rem_sh = {r_rem, r_quot[DIV_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_div};
    assign w_diff   = w_rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (r_step == DIV_STEP_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 1'b1;
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DIV_W-1:0] : w_rem_sh[DIV_W-1:0];
            r_quot <= {r_quot[DIV_W-2:0], w_ge};
        end else if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule
`default_nettype wire

// ===== rtl/tte_front.sv =====
`default_nettype none
module tte_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_button_pressed,
    input  wire logic [tte_pkg::TIMEOUT_W-1:0] i_timeout,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output tte_pkg::t_job                      o_job
);
    import tte_pkg::*;

    logic [TICK_W-1:0] r_ticks;
    logic [TICK_W-1:0] w_ticks_inc;
    logic              w_accept;

    assign o_in_ready  = !i_q_full;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_ticks_inc = (r_ticks == {TICK_W{1'b1}}) ? r_ticks : r_ticks + 1'b1;

    // A press that is not past the timeout has at most TIMEOUT_W bits of ticks.
    assign o_push        = w_accept && i_button_pressed;
    assign o_job.cleared = w_ticks_inc > TICK_W'(i_timeout);
    assign o_job.ticks   = w_ticks_inc[TIMEOUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= '0;
        end else if (w_accept) begin
            r_ticks <= i_button_pressed ? '0 : w_ticks_inc;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tte_queue.sv =====
`default_nettype none
module tte_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tte_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output tte_pkg::t_job      o_job
);
    import tte_pkg::*;

    t_job                   r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wp;
    logic [QUEUE_PTR_W-1:0] r_rp;
    logic [QUEUE_CNT_W-1:0] r_cnt;
    logic                   w_do_push;
    logic                   w_do_pop;

    assign o_full    = r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign o_valid   = r_cnt != '0;
    assign o_job     = r_slot[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tte_back.sv =====
`default_nettype none
module tte_back #(
    parameter int HISTORY_DEPTH = tte_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [tte_pkg::PERIOD_W-1:0] i_tick_period,
    input  wire logic                         i_q_valid,
    input  wire tte_pkg::t_job                i_job,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_history_cleared,
    output logic [tte_pkg::TEMPO_W-1:0]       o_tempo_q8,
    output logic [tte_pkg::TEMPO_W-1:0]       o_average_q8
);
    import tte_pkg::*;

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int IDX_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = TEMPO_W + IDX_W;
    localparam logic [IDX_W-1:0]  DEPTH_L     = IDX_W'(HISTORY_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT_L = SLOT_W'(HISTORY_DEPTH - 1);

    t_back_state r_state;
    t_back_state n_state;

    logic [TEMPO_W-1:0]       r_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_hist_vld;
    logic [SLOT_W-1:0]        r_slot;
    logic [TIMEOUT_W-1:0]     r_ticks;
    logic [DIV_W-1:0]         r_prod;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_rd_pend;
    logic                     r_rd_vbit;
    logic [TEMPO_W-1:0]       r_rd_data;
    logic [SUM_W-1:0]         r_sum;
    logic [IDX_W-1:0]         r_cnt;
    logic                     r_out_valid;
    logic                     r_cleared;
    logic [TEMPO_W-1:0]       r_tempo;
    logic [TEMPO_W-1:0]       r_avg;

    logic                     w_div_start;
    logic [DIV_W-1:0]         w_div_dividend;
    logic [DIV_W-1:0]         w_div_divisor;
    logic                     w_div_done;
    logic [DIV_W-1:0]         w_div_quot;
    logic                     w_mem_we;
    logic                     w_rd_en;
    logic [SLOT_W-1:0]        w_rd_addr;

    tte_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quot)
    );

    assign w_rd_addr = r_idx[SLOT_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    n_state = i_job.cleared ? B_IDLE : B_MUL;
                end
            end
            B_MUL:    n_state = B_TSTART;
            B_TSTART: n_state = B_TWAIT;
            B_TWAIT: begin
                if (w_div_done) begin
                    n_state = B_WRITE;
                end
            end
            B_WRITE:  n_state = B_SUM;
            B_SUM: begin
                if (r_idx == DEPTH_L && !r_rd_pend) begin
                    n_state = B_ASTART;
                end
            end
            B_ASTART: n_state = B_AWAIT;
            B_AWAIT: begin
                if (w_div_done) begin
                    n_state = B_IDLE;
                end
            end
            default:  n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop          = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = MINUTE_US_Q8;
        w_div_divisor  = r_prod;
        w_mem_we       = 1'b0;
        w_rd_en        = 1'b0;
        case (r_state)
            B_IDLE:   o_pop = i_q_valid && !r_out_valid;
            B_TSTART: w_div_start = 1'b1;
            B_WRITE:  w_mem_we = 1'b1;
            B_SUM:    w_rd_en = r_idx != DEPTH_L;
            B_ASTART: begin
                w_div_start    = 1'b1;
                w_div_dividend = DIV_W'(r_sum);
                w_div_divisor  = DIV_W'(r_cnt);
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_hist_vld  <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= w_rd_en;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && i_job.cleared) begin
                r_hist_vld  <= '0;
                r_out_valid <= 1'b1;
            end
            if (w_mem_we) begin
                r_hist_vld[r_slot] <= 1'b1;
                r_slot <= (r_slot == LAST_SLOT_L) ? '0 : r_slot + 1'b1;
            end
            if (r_state == B_AWAIT && w_div_done) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_slot] <= r_tempo;
        end
        r_rd_data <= r_mem[w_rd_addr];
        r_rd_vbit <= r_hist_vld[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ticks   <= i_job.ticks;
            r_cleared <= i_job.cleared;
            r_tempo   <= '0;
            r_avg     <= '0;
        end
        if (r_state == B_MUL) begin
            r_prod <= DIV_W'(r_ticks * i_tick_period);
        end
        if (r_state == B_TWAIT && w_div_done) begin
            r_tempo <= (w_div_quot[DIV_W-1:TEMPO_W] != '0) ? Q8_MAX
                                                           : w_div_quot[TEMPO_W-1:0];
        end
        if (w_mem_we) begin
            r_idx <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end
        if (w_rd_en) begin
            r_idx <= r_idx + 1'b1;
        end
        // An entry never written since the last clear reads as zero.
        if (r_rd_pend && r_rd_vbit && r_rd_data != '0) begin
            r_sum <= r_sum + SUM_W'(r_rd_data);
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == B_AWAIT && w_div_done) begin
            r_avg <= (r_cnt == '0) ? '0 : w_div_quot[TEMPO_W-1:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_history_cleared = r_cleared;
    assign o_tempo_q8        = r_tempo;
    assign o_average_q8      = r_avg;

endmodule
`default_nettype wire

// ===== rtl/tap_tempo_estimator.sv =====
`default_nettype none
// Channel   Handshake                   Payload
// input     i_in_valid / o_in_ready     i_button_pressed
// output    o_out_valid / i_out_ready   o_history_cleared, o_tempo_q8, o_average_q8
// config    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A tick without a press gives no result.
// A press past the timeout gives its result as the back end pops it off the queue.
// Any other press takes two 34-step passes through the shared bit-serial divider
// and a sweep over the history memory.
// Two presses can wait in the queue while the back end works or its result stalls.
// Reset clears the tick count, write slot and history valid bits at once.
module tap_tempo_estimator #(
    parameter int HISTORY_DEPTH = tte_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_button_pressed,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_history_cleared,
    output logic [tte_pkg::TEMPO_W-1:0]         o_tempo_q8,
    output logic [tte_pkg::TEMPO_W-1:0]         o_average_q8,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tte_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tte_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tte_pkg::*;

    logic [PERIOD_W-1:0]  r_tick_period;
    logic [TIMEOUT_W-1:0] r_timeout;
    logic                 w_push;
    t_job                 w_push_job;
    logic                 w_q_full;
    logic                 w_q_valid;
    t_job                 w_q_job;
    logic                 w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= TICK_PERIOD_RESET;
            r_timeout     <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_TICK_PERIOD) begin
                r_tick_period <= i_cfg_data[PERIOD_W-1:0];
            end
            if (i_cfg_index == CFG_TIMEOUT) begin
                r_timeout <= i_cfg_data[TIMEOUT_W-1:0];
            end
        end
    end

    tte_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_button_pressed (i_button_pressed),
        .i_timeout        (r_timeout),
        .i_q_full         (w_q_full),
        .o_push           (w_push),
        .o_job            (w_push_job)
    );

    tte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    tte_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tick_period     (r_tick_period),
        .i_q_valid         (w_q_valid),
        .i_job             (w_q_job),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_history_cleared (o_history_cleared),
        .o_tempo_q8        (o_tempo_q8),
        .o_average_q8      (o_average_q8)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("press request pushed into a full queue");

    a_cleared_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_history_cleared |-> o_tempo_q8 == '0 && o_average_q8 == '0)
        else $error("cleared result carries a nonzero tempo");

    a_tempo_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_history_cleared |-> o_tempo_q8 != '0 && o_average_q8 != '0)
        else $error("tempo result without a tempo or an average");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid && !o_out_valid)
        else $error("queue popped while empty or while a result waits");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import tte_pkg::*;

    localparam int RING_DEPTH = HISTORY_DEPTH_DEF;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS = 120;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LAST = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic press;
        logic rush;
    } t_tap_tick;

    typedef struct packed {
        logic               cleared;
        logic [TEMPO_W-1:0] tempo;
        logic [TEMPO_W-1:0] average;
    } t_tempo_report;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_button_pressed = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_history_cleared;
    logic [TEMPO_W-1:0]    o_tempo_q8;
    logic [TEMPO_W-1:0]    o_average_q8;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor state, kept in step with every accepted tick and register write.
    logic [TICK_W-1:0]    ticks_elapsed;
    logic [5:0]           slot_ptr;
    logic [TEMPO_W-1:0]   tempo_ring [RING_DEPTH];
    logic [PERIOD_W-1:0]  period_us;
    logic [TIMEOUT_W-1:0] timeout_limit;

    t_tempo_report expected_reports[$];
    t_tap_tick     pending_ticks[$];

    logic [TIMEOUT_W-1:0] stim_timeout = TIMEOUT_RESET;
    logic        tick_taken = 1'b0;
    logic        report_taken = 1'b0;
    logic        receiver_hold = 1'b0;
    bit          hold_req = 1'b0;
    bit          in_burst = 1'b0;
    bit          out_burst = 1'b0;
    int unsigned in_gap = 0;
    int unsigned out_stall = 0;
    int unsigned fail_count = 0;
    t_tap_tick   next_tick;

    tap_tempo_estimator i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_button_pressed  (i_button_pressed),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_history_cleared (o_history_cleared),
        .o_tempo_q8        (o_tempo_q8),
        .o_average_q8      (o_average_q8),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_predictor();
        ticks_elapsed = '0;
        slot_ptr = '0;
        foreach (tempo_ring[i]) tempo_ring[i] = '0;
        period_us = TICK_PERIOD_RESET;
        timeout_limit = TIMEOUT_RESET;
        expected_reports.delete();
    endfunction

    function automatic logic [TEMPO_W-1:0] interval_tempo(input logic [TICK_W-1:0] ticks);
        logic [63:0] divisor;
        logic [63:0] quotient;
        divisor = 64'(ticks) * 64'(period_us);
        // A zero period leaves nothing to divide by, so the tempo pins at full scale.
        if (divisor == 64'd0) return Q8_MAX;
        quotient = 64'(MINUTE_US_Q8) / divisor;
        if (quotient > 64'(Q8_MAX)) return Q8_MAX;
        return quotient[TEMPO_W-1:0];
    endfunction

    function automatic logic [TEMPO_W-1:0] ring_mean();
        logic [63:0] total;
        int unsigned used;
        total = '0;
        used = 0;
        foreach (tempo_ring[i]) begin
            if (tempo_ring[i] != '0) begin
                total += 64'(tempo_ring[i]);
                used++;
            end
        end
        if (used == 0) return '0;
        return TEMPO_W'(total / 64'(used));
    endfunction

    function automatic void predict_tick(input logic press);
        t_tempo_report rep;
        logic [TICK_W-1:0] ticks;
        if (ticks_elapsed != '1) ticks_elapsed++;
        if (!press) return;
        ticks = ticks_elapsed;
        ticks_elapsed = '0;
        if (ticks > TICK_W'(timeout_limit)) begin
            // The write slot is left where it is on a clear.
            foreach (tempo_ring[i]) tempo_ring[i] = '0;
            rep = '{cleared: 1'b1, tempo: '0, average: '0};
        end else begin
            rep.cleared = 1'b0;
            rep.tempo = interval_tempo(ticks);
            if (slot_ptr >= RING_DEPTH) slot_ptr = '0;
            tempo_ring[slot_ptr] = rep.tempo;
            slot_ptr = (slot_ptr == RING_DEPTH - 1) ? '0 : slot_ptr + 6'd1;
            rep.average = ring_mean();
        end
        expected_reports.push_back(rep);
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TICK_PERIOD: period_us = data[PERIOD_W-1:0];
            CFG_TIMEOUT: timeout_limit = data[TIMEOUT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    function automatic void check_report();
        t_tempo_report want;
        if (expected_reports.size() == 0) begin
            note_failure($sformatf("unexpected result: cleared=%0b tempo=%0d average=%0d",
                                   o_history_cleared, o_tempo_q8, o_average_q8));
            return;
        end
        want = expected_reports.pop_front();
        if (o_history_cleared !== want.cleared || o_tempo_q8 !== want.tempo ||
            o_average_q8 !== want.average) begin
            note_failure($sformatf(
                "result mismatch: expected cleared=%0b tempo=%0d average=%0d, got %0b %0d %0d",
                want.cleared, want.tempo, want.average,
                o_history_cleared, o_tempo_q8, o_average_q8));
        end
    endfunction

    always @(posedge i_clk) begin
        tick_taken <= i_rst_n && i_in_valid && o_in_ready;
        report_taken <= i_rst_n && o_out_valid && i_out_ready;
        if (!i_rst_n) begin
            clear_predictor();
        end else begin
            if (i_cfg_valid && o_cfg_ready) apply_config(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) predict_tick(i_button_pressed);
            if (o_out_valid && i_out_ready) check_report();
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || tick_taken) begin
            if (in_gap != 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                next_tick = pending_ticks.pop_front();
                i_in_valid <= 1'b1;
                i_button_pressed <= next_tick.press;
                if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
                in_gap = (in_burst || next_tick.rush) ? 0 : $urandom_range(0, 15);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (report_taken) begin
                if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
                out_stall = out_burst ? 0 : $urandom_range(0, 15);
            end
            if (receiver_hold) begin
                i_out_ready <= 1'b0;
            end else if (out_stall != 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Long receiver stall so that queued presses back up into the input.
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        receiver_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        receiver_hold <= 1'b0;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    task automatic add_interval(input int unsigned len, input logic rush);
        repeat (len - 1) pending_ticks.push_back('{press: 1'b0, rush: rush});
        pending_ticks.push_back('{press: 1'b1, rush: rush});
    endtask

    // Returns once every tick went in and every result came out, plus slack for
    // work that produces no result.
    task automatic settle();
        while (pending_ticks.size() != 0 || i_in_valid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TIMEOUT) stim_timeout = data[TIMEOUT_W-1:0];
    endtask

    task automatic random_phase(input int unsigned n_ticks);
        int unsigned queued;
        int unsigned len;
        int unsigned span;
        int unsigned pick;
        queued = 0;
        span = (stim_timeout < 40) ? stim_timeout : 40;
        while (queued < n_ticks) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                pending_ticks.push_back('{press: 1'($urandom), rush: 1'b0});
                len = 1;
            end else begin
                if (pick == 1 && stim_timeout <= 200)
                    len = stim_timeout + $urandom_range(1, 4);
                else if (pick == 2 && stim_timeout <= 200)
                    len = stim_timeout;
                else
                    len = $urandom_range(1, span);
                add_interval(len, 1'b0);
            end
            queued += len;
        end
    endtask

    initial begin
        logic [PERIOD_W-1:0]  period_pick;
        logic [TIMEOUT_W-1:0] timeout_pick;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of both registers.
        add_interval(1, 1'b0);
        add_interval(1, 1'b0);
        add_interval(2, 1'b0);
        add_interval(5, 1'b0);
        settle();

        // Zero period, shortest timeout: saturated tempo, then a clear.
        write_reg(CFG_TICK_PERIOD, 32'hFFFE_0000);
        write_reg(CFG_TIMEOUT, ($urandom & 32'hFFFF_0000) | 32'd1);
        add_interval(1, 1'b0);
        add_interval(2, 1'b0);
        add_interval(1, 1'b0);
        add_interval(1, 1'b0);
        settle();

        // Tiny period overflows the quotient; a long timeout is hit exactly
        // and then exceeded by one tick.
        write_reg(CFG_TICK_PERIOD, ($urandom & 32'hFFFE_0000) | 32'd1);
        write_reg(CFG_TIMEOUT, 32'h0000_00C8);
        add_interval(1, 1'b0);
        add_interval(200, 1'b1);
        add_interval(201, 1'b1);
        add_interval(1, 1'b0);
        settle();

        // Largest period, then writes to unused indexes that must change nothing.
        write_reg(CFG_TICK_PERIOD, 32'hFFFF_FFFF);
        write_reg(CFG_TIMEOUT, ($urandom & 32'hFFFF_0000) | 32'd2);
        add_interval(1, 1'b0);
        add_interval(2, 1'b0);
        add_interval(3, 1'b0);
        add_interval(2, 1'b0);
        settle();
        write_reg(CFG_SPARE, $urandom);
        write_reg(CFG_LAST, 32'hFFFF_FFFF);
        add_interval(1, 1'b0);
        add_interval(2, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: period_pick = PERIOD_W'(1000);
                1: period_pick = PERIOD_W'(100000);
                2: period_pick = PERIOD_W'($urandom_range(1000, 100000));
                default: period_pick = PERIOD_W'($urandom);
            endcase
            case (p % 4)
                0: timeout_pick = TIMEOUT_W'($urandom_range(2, 40));
                1: timeout_pick = TIMEOUT_RESET;
                2: timeout_pick = '1;
                default: timeout_pick = TIMEOUT_W'(1);
            endcase
            settle();
            write_reg(CFG_TICK_PERIOD, ($urandom & 32'hFFFE_0000) | 32'(period_pick));
            write_reg(CFG_TIMEOUT, ($urandom & 32'hFFFF_0000) | 32'(timeout_pick));
            if (p == 0) hold_req = 1'b1;
            random_phase(PHASE_TICKS);
        end

        settle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
